// ===== hw/rtl/tmss_pkg.sv =====
package tmss_pkg;

    // Default geometry.
    localparam int WINDOW_DEF    = 11;
    localparam int STEP_BITS_DEF = 32;

    // Field widths.
    localparam int DATA_W     = 32;
    localparam int SPEED_W    = 24;
    localparam int LERP_W     = 16;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 32;

    // Fixed-point scaling: speed factor is Q8.16, lerp factor is Q0.16.
    localparam int SPEED_FRAC = 16;
    localparam int SCALE_HALF = 1 << (SPEED_FRAC - 1);
    localparam int LERP_HALF  = 1 << (LERP_W - 1);

    // Register reset values.
    localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(65536);
    localparam logic [DATA_W-1:0]  MIN_RST   = DATA_W'(1000000);
    localparam logic [DATA_W-1:0]  MAX_RST   = DATA_W'(100000000);
    localparam logic [LERP_W-1:0]  LERP_RST  = LERP_W'(13107);

    // Register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_FACTOR = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MIN_STEP     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_MAX_STEP     = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_LERP_FACTOR  = CFG_IDX_W'(3);

    // Item operations.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // Trimmed mean: sorted ranks RANK_LO..RANK_HI, rounded to nearest.
    localparam int RANK_LO    = 2;
    localparam int RANK_HI    = 8;
    localparam int RANK_CNT   = RANK_HI - RANK_LO + 1;
    localparam int RANK_CNT_W = $clog2(RANK_CNT);
    localparam int ROUND_BIAS = RANK_CNT / 2;
    localparam int SUM_W      = DATA_W + $clog2(RANK_CNT);

    // Division by seven, one byte per step with a reciprocal multiply.
    localparam int DIGIT_W    = 8;
    localparam int DIV_DIGITS = (SUM_W + DIGIT_W - 1) / DIGIT_W;
    localparam int DIV_W      = DIV_DIGITS * DIGIT_W;
    localparam int REM_W      = 3;
    localparam int PART_W     = REM_W + DIGIT_W;
    localparam int DIV_MAGIC  = 18725;
    localparam int DIV_SHIFT  = 17;
    localparam int MAGIC_W    = 15;

    // Control of one sorting cell.
    typedef struct packed {
        logic load;
        logic run;
        logic pair_right;
        logic pair_left;
    } sort_ctrl_t;

endpackage

// ===== hw/rtl/tmss_scale.sv =====
module tmss_scale
    import tmss_pkg::*;
#(
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [DATA_W-1:0]  raw_step,
    input  logic [SPEED_W-1:0] speed_factor,
    input  logic [DATA_W-1:0]  min_step,
    input  logic [DATA_W-1:0]  max_step,
    output logic               out_valid,
    output logic [DATA_W-1:0]  out_step
);

    localparam int PROD_W = DATA_W + SPEED_W;
    localparam int RND_W  = PROD_W - SPEED_FRAC;
    localparam int EXT_W  = (STEP_BITS > RND_W) ? STEP_BITS : RND_W;
    localparam logic [EXT_W-1:0] STEP_MAX = EXT_W'({STEP_BITS{1'b1}});

    logic [PROD_W-1:0] prod_reg;
    logic [EXT_W-1:0]  sat_reg;
    logic [DATA_W-1:0] step_reg;
    logic [2:0]        vld_reg;
    logic [PROD_W-1:0] rnd_sum;
    logic [EXT_W-1:0]  rnd_ext;

    assign rnd_sum = prod_reg + PROD_W'(SCALE_HALF);
    assign rnd_ext = EXT_W'(rnd_sum[PROD_W-1:SPEED_FRAC]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PROD_W'(raw_step) * PROD_W'(speed_factor);
        sat_reg  <= (rnd_ext > STEP_MAX) ? STEP_MAX : rnd_ext;
        if (sat_reg < EXT_W'(min_step)) begin
            step_reg <= min_step;
        end else if (sat_reg > EXT_W'(max_step)) begin
            step_reg <= max_step;
        end else begin
            step_reg <= sat_reg[DATA_W-1:0];
        end
    end

    assign out_valid = vld_reg[2];
    assign out_step  = step_reg;

endmodule

// ===== hw/rtl/tmss_sort_cell.sv =====
module tmss_sort_cell
    import tmss_pkg::*;
(
    input  logic              aclk,
    input  sort_ctrl_t        ctrl,
    input  logic [DATA_W-1:0] load_val,
    input  logic [DATA_W-1:0] left_val,
    input  logic [DATA_W-1:0] right_val,
    output logic [DATA_W-1:0] val
);

    logic [DATA_W-1:0] val_reg;

    // Odd-even transposition: the left cell of a pair keeps the smaller value,
    // the right cell keeps the larger one.
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            val_reg <= load_val;
        end else if (ctrl.run) begin
            if (ctrl.pair_right && (right_val < val_reg)) begin
                val_reg <= right_val;
            end else if (ctrl.pair_left && (left_val > val_reg)) begin
                val_reg <= left_val;
            end
        end
    end

    assign val = val_reg;

endmodule

// ===== hw/rtl/tmss_div7.sv =====
module tmss_div7
    import tmss_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIV_W-1:0]  dividend,
    output logic              done,
    output logic [DATA_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_DIGITS);
    localparam int MUL_W = PART_W + MAGIC_W;

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [DIV_W-1:0] dvd_reg;
    logic [DIV_W-1:0] quo_reg;
    logic [REM_W-1:0] rem_reg;

    logic [PART_W-1:0]  part;
    logic [MUL_W-1:0]   mul;
    logic [DIGIT_W-1:0] qdig;
    logic [PART_W-1:0]  back;
    logic [PART_W-1:0]  rem_full;

    // The partial dividend stays below 7 * 256, where the reciprocal is exact.
    assign part     = {rem_reg, dvd_reg[DIV_W-1 -: DIGIT_W]};
    assign mul      = MUL_W'(part) * MUL_W'(DIV_MAGIC);
    assign qdig     = mul[DIV_SHIFT +: DIGIT_W];
    assign back     = PART_W'(qdig) * PART_W'(RANK_CNT);
    assign rem_full = part - back;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DIV_DIGITS - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            dvd_reg <= dvd_reg << DIGIT_W;
            quo_reg <= {quo_reg[DIV_W-DIGIT_W-1:0], qdig};
            rem_reg <= rem_full[REM_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg[DATA_W-1:0];

endmodule

// ===== hw/rtl/trimmed_mean_step_smoother_top.sv =====
// A sample inside the warm-up phase goes from the scaler straight to the output register;
// a sample over a full window first passes the row of sorting cells (WINDOW rounds), the
// trimmed sum, the byte-wise divide by seven and the blend. The block takes no new sample
// until the last one's result is loaded into the output register. A clear beat gives no
// result and leaves the input ready. Reset is synchronous and active low; it restores the
// register defaults and empties the history.
module trimmed_mean_step_smoother_top
    import tmss_pkg::*;
#(
    parameter int WINDOW    = WINDOW_DEF,
    parameter int STEP_BITS = STEP_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_op,
    input  logic [DATA_W-1:0]     s_raw_step,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [DATA_W-1:0]     m_smoothed_step,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int FILL_W = $clog2(WINDOW + 1);
    localparam int IDX_W  = $clog2(WINDOW);
    localparam int HIST_D = WINDOW - 1;
    localparam int WARMUP = WINDOW - 1;
    localparam int PROD_W = DATA_W + LERP_W;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCALE = 4'd1;
    localparam logic [3:0] ST_SORT  = 4'd2;
    localparam logic [3:0] ST_SUM   = 4'd3;
    localparam logic [3:0] ST_DIV   = 4'd4;
    localparam logic [3:0] ST_DIFF  = 4'd5;
    localparam logic [3:0] ST_MUL   = 4'd6;
    localparam logic [3:0] ST_ROUND = 4'd7;
    localparam logic [3:0] ST_APPLY = 4'd8;
    localparam logic [3:0] ST_OUT   = 4'd9;

    // Configuration registers. The port never stalls a write, and writes to an
    // index beyond the register list are dropped.
    logic [SPEED_W-1:0] speed_reg;
    logic [DATA_W-1:0]  min_reg;
    logic [DATA_W-1:0]  max_reg;
    logic [LERP_W-1:0]  lerp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= SPEED_RST;
            min_reg   <= MIN_RST;
            max_reg   <= MAX_RST;
            lerp_reg  <= LERP_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SPEED_FACTOR: speed_reg <= cfg_data[SPEED_W-1:0];
                REG_MIN_STEP:     min_reg   <= cfg_data[DATA_W-1:0];
                REG_MAX_STEP:     max_reg   <= cfg_data[DATA_W-1:0];
                REG_LERP_FACTOR:  lerp_reg  <= cfg_data[LERP_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer and control registers.
    logic [3:0]            state_reg;
    logic [3:0]            state_next;
    logic [FILL_W-1:0]     fill_reg;
    logic [IDX_W-1:0]      sort_cnt_reg;
    logic [RANK_CNT_W-1:0] sum_cnt_reg;
    logic                  m_valid_reg;
    logic [DATA_W-1:0]     m_data_reg;

    // Datapath registers.
    logic [DATA_W-1:0] hist_reg [HIST_D];
    logic [DATA_W-1:0] last_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [DATA_W-1:0] avg_reg;
    logic              ge_reg;
    logic [DATA_W-1:0] mag_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DATA_W-1:0] stepd_reg;

    logic              in_beat;
    logic              sample_go;
    logic              scale_done;
    logic [DATA_W-1:0] scale_step;
    logic              warm;
    logic              sort_load;
    logic              sort_last;
    logic              sum_last;
    logic              out_load;
    logic              div_done;
    logic [DATA_W-1:0] div_quo;
    logic [IDX_W-1:0]  sum_sel;
    logic [SUM_W-1:0]  acc_next;
    logic [PROD_W-1:0] prod_rnd;
    logic [DATA_W-1:0] sort_val [WINDOW];

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_beat   = s_valid && s_ready;
    assign sample_go = in_beat && (s_op == OP_SAMPLE);
    assign warm      = (fill_reg < FILL_W'(WARMUP));
    assign sort_load = (state_reg == ST_SCALE) && scale_done && !warm;
    assign sort_last = (sort_cnt_reg == IDX_W'(WINDOW - 1));
    assign sum_last  = (sum_cnt_reg == RANK_CNT_W'(RANK_CNT - 1));
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);

    // The scaler is a three-stage pipeline: multiply, round and saturate,
    // then clamp to the configured bounds.
    tmss_scale #(
        .STEP_BITS (STEP_BITS)
    ) u_scale (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (sample_go),
        .raw_step     (s_raw_step),
        .speed_factor (speed_reg),
        .min_step     (min_reg),
        .max_step     (max_reg),
        .out_valid    (scale_done),
        .out_step     (scale_step)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (sample_go) state_next = ST_SCALE;
            ST_SCALE: begin
                if (scale_done) begin
                    state_next = warm ? ST_OUT : ST_SORT;
                end
            end
            ST_SORT:  if (sort_last) state_next = ST_SUM;
            ST_SUM:   if (sum_last) state_next = ST_DIV;
            ST_DIV:   if (div_done) state_next = ST_DIFF;
            ST_DIFF:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_APPLY;
            ST_APPLY: state_next = ST_OUT;
            ST_OUT:   if (out_load) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            sort_cnt_reg <= '0;
            sum_cnt_reg  <= '0;
            last_reg     <= '0;
        end else begin
            state_reg <= state_next;
            if (in_beat && (s_op == OP_CLEAR)) begin
                fill_reg <= '0;
            end else if ((state_reg == ST_SCALE) && scale_done) begin
                if (fill_reg < FILL_W'(WINDOW)) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                if (warm) begin
                    last_reg <= scale_step;
                end
            end
            if (sort_load) begin
                sort_cnt_reg <= '0;
            end else if (state_reg == ST_SORT) begin
                sort_cnt_reg <= sort_cnt_reg + 1'b1;
            end
            if (state_reg == ST_SORT) begin
                sum_cnt_reg <= '0;
            end else if (state_reg == ST_SUM) begin
                sum_cnt_reg <= sum_cnt_reg + 1'b1;
            end
            if (state_reg == ST_APPLY) begin
                last_reg <= ge_reg ? (last_reg + stepd_reg) : (last_reg - stepd_reg);
            end
        end
    end

    // The history is a shift line of the WINDOW-1 previous samples; together
    // with the new sample it forms the full window that the cells load.
    always_ff @(posedge aclk) begin
        if ((state_reg == ST_SCALE) && scale_done) begin
            hist_reg[0] <= scale_step;
            for (int i = 1; i < HIST_D; i++) begin
                hist_reg[i] <= hist_reg[i-1];
            end
        end
    end

    // Row of sorting cells. In round k the cells pair up starting at cell
    // k mod 2, and each pair swaps into order; WINDOW rounds sort the row.
    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        sort_ctrl_t        ctrl;
        logic [DATA_W-1:0] load_v;
        logic [DATA_W-1:0] left_v;
        logic [DATA_W-1:0] right_v;

        assign ctrl.load       = sort_load;
        assign ctrl.run        = (state_reg == ST_SORT);
        assign ctrl.pair_right = (1'(g % 2) == sort_cnt_reg[0]) && (g < WINDOW - 1);
        assign ctrl.pair_left  = (1'(g % 2) != sort_cnt_reg[0]) && (g > 0);

        if (g == 0) begin : g_first
            assign load_v = scale_step;
            assign left_v = '0;
        end else begin : g_rest
            assign load_v = hist_reg[g-1];
            assign left_v = sort_val[g-1];
        end

        if (g == WINDOW - 1) begin : g_last
            assign right_v = '0;
        end else begin : g_inner
            assign right_v = sort_val[g+1];
        end

        tmss_sort_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .load_val  (load_v),
            .left_val  (left_v),
            .right_val (right_v),
            .val       (sort_val[g])
        );
    end

    // The trimmed sum walks the middle ranks one per cycle. The accumulator
    // starts at the rounding bias so that the divider sees sum + 3.
    assign sum_sel  = IDX_W'(RANK_LO) + IDX_W'(sum_cnt_reg);
    assign acc_next = acc_reg + SUM_W'(sort_val[sum_sel]);

    always_ff @(posedge aclk) begin
        if (state_reg == ST_SORT) begin
            acc_reg <= SUM_W'(ROUND_BIAS);
        end else if (state_reg == ST_SUM) begin
            acc_reg <= acc_next;
        end
    end

    tmss_div7 u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    ((state_reg == ST_SUM) && sum_last),
        .dividend (DIV_W'(acc_next)),
        .done     (div_done),
        .quotient (div_quo)
    );

    // Blend: the magnitude of the gap is scaled by the lerp factor, rounded
    // half up, and then moved toward the average, so halves round away from
    // the previous value and the result never overshoots.
    assign prod_rnd = prod_reg + PROD_W'(LERP_HALF);

    always_ff @(posedge aclk) begin
        if ((state_reg == ST_DIV) && div_done) begin
            avg_reg <= div_quo;
        end
        if (state_reg == ST_DIFF) begin
            ge_reg  <= (avg_reg >= last_reg);
            mag_reg <= (avg_reg >= last_reg) ? (avg_reg - last_reg) : (last_reg - avg_reg);
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= PROD_W'(mag_reg) * PROD_W'(lerp_reg);
        end
        if (state_reg == ST_ROUND) begin
            stepd_reg <= prod_rnd[PROD_W-1:LERP_W];
        end
    end

    // Output register: the result waits here until the sink takes the beat.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= last_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_smoothed_step = m_data_reg;

endmodule

// ===== hw/rtl/tmss_checker.sv =====
module tmss_checker
    import tmss_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              s_op,
    input logic              m_valid,
    input logic              m_ready,
    input logic [DATA_W-1:0] m_smoothed_step
);

    // A stalled result beat holds its data.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_smoothed_step))
        else $error("result beat changed while stalled");

    // Reset empties the output register.
    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result beat present after reset");

    // A sample occupies the block: no new beat is taken in the next cycle.
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_SAMPLE) |=> !s_ready)
        else $error("input taken while a sample is in progress");

    // A clear finishes at once and leaves the input open.
    a_clear_fast: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_CLEAR) |=> s_ready)
        else $error("clear beat stalled the input");

    // The sample must pass the scaler first, so no result rises right after it.
    a_no_early: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_op == OP_SAMPLE) |=> !$rose(m_valid))
        else $error("result appeared too early");

endmodule

bind trimmed_mean_step_smoother_top tmss_checker u_tmss_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .s_op            (s_op),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_smoothed_step (m_smoothed_step)
);

// ===== bench/tb_trimmed_mean_step_smoother_top.sv =====
`timescale 1ns / 1ps

module tb_trimmed_mean_step_smoother_top;
    import tmss_pkg::*;

    // Saturation ceiling of the scaled step, 2^STEP_BITS - 1.
    localparam logic [63:0] STEP_CEIL = (64'd1 << STEP_BITS_DEF) - 64'd1;

    // The deepest result in the block runs through the sort, the sum, the divider and the
    // blend; this many idle cycles are enough to be sure that nothing is still in flight.
    localparam int SETTLE_CYCLES = WINDOW_DEF + 30;

    // The first index past the register list; writes there must be dropped.
    localparam logic [CFG_IDX_W-1:0] REG_PAST_END = CFG_IDX_W'(4);

    localparam int PHASE_ITEMS = 112;
    localparam int HOLD_CYCLES = 400;
    localparam int SHOW_LIMIT  = 10;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_op = OP_SAMPLE;
    logic [DATA_W-1:0]     s_raw_step = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [DATA_W-1:0]     m_smoothed_step;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = REG_SPEED_FACTOR;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    trimmed_mean_step_smoother_top u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_op            (s_op),
        .s_raw_step      (s_raw_step),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_smoothed_step (m_smoothed_step),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // A hard ceiling on the run. The slowest legal run is well under a tenth of this.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Shadow copy of the smoother: its registers, the sample ring and the held output.
    // ------------------------------------------------------------------------------------
    logic [SPEED_W-1:0] shadow_speed = SPEED_RST;
    logic [DATA_W-1:0]  shadow_min   = MIN_RST;
    logic [DATA_W-1:0]  shadow_max   = MAX_RST;
    logic [LERP_W-1:0]  shadow_lerp  = LERP_RST;

    logic [DATA_W-1:0]  ring_steps [WINDOW_DEF];
    int unsigned        ring_fill = 0;
    int unsigned        ring_slot = 0;
    logic [DATA_W-1:0]  held_step = '0;

    // Smoothed steps still owed by the block, oldest first.
    logic [DATA_W-1:0]  smoothed_due [$];

    int  mismatch_count = 0;
    bit  steady = 1'b0;      // when set, neither side idles
    bit  hold_req = 1'b0;    // asks the receiver for one long hold-off

    // Scales and clamps one raw step, pushes it into the ring and returns the new
    // smoothed step. While the ring is still filling the clamped value is returned as
    // it is; once it is full the ring is sorted, the middle seven ranks are averaged,
    // and the held value moves toward that average by the blend weight.
    function automatic logic [DATA_W-1:0] predict_smoothed(input logic [DATA_W-1:0] raw);
        logic [63:0] scaled;
        logic [63:0] ordered [WINDOW_DEF];
        logic [63:0] pick;
        logic [63:0] total;
        logic [63:0] avg;
        logic [63:0] last;
        int          j;

        scaled = ({32'b0, raw} * {40'b0, shadow_speed} + 64'(SCALE_HALF)) >> SPEED_FRAC;
        if (scaled > STEP_CEIL) begin
            scaled = STEP_CEIL;
        end
        // Min is tested first, so with min above max every value lands on a bound.
        if (scaled < {32'b0, shadow_min}) begin
            scaled = {32'b0, shadow_min};
        end else if (scaled > {32'b0, shadow_max}) begin
            scaled = {32'b0, shadow_max};
        end

        ring_steps[ring_slot] = scaled[DATA_W-1:0];
        ring_slot = (ring_slot == WINDOW_DEF - 1) ? 0 : ring_slot + 1;
        if (ring_fill < WINDOW_DEF) begin
            ring_fill++;
        end

        if (ring_fill < WINDOW_DEF) begin
            held_step = scaled[DATA_W-1:0];
            return held_step;
        end

        for (int i = 0; i < WINDOW_DEF; i++) begin
            pick = {32'b0, ring_steps[i]};
            j = i;
            while (j > 0 && ordered[j-1] > pick) begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = pick;
        end
        total = '0;
        for (int i = RANK_LO; i <= RANK_HI; i++) begin
            total += ordered[i];
        end
        avg  = (total + 64'(ROUND_BIAS)) / 64'(RANK_CNT);
        last = {32'b0, held_step};

        // The step is rounded on the distance, so halves round away from the held value.
        if (avg >= last) begin
            last = last + (((avg - last) * {48'b0, shadow_lerp} + 64'(LERP_HALF)) >> LERP_W);
        end else begin
            last = last - (((last - avg) * {48'b0, shadow_lerp} + 64'(LERP_HALF)) >> LERP_W);
        end
        held_step = last[DATA_W-1:0];
        return held_step;
    endfunction

    // ------------------------------------------------------------------------------------
    // Sender side.
    // ------------------------------------------------------------------------------------

    // Offers one beat and returns at the edge where it is taken. The caller decides what
    // happens to s_valid afterwards, so valid is never dropped and raised in one step.
    // A row with a hand-typed result checks against that value instead of the shadow.
    task automatic send_beat(input logic op, input logic [DATA_W-1:0] raw,
                             input bit typed, input logic [DATA_W-1:0] want);
        logic [DATA_W-1:0] got;

        if (!steady && $urandom_range(0, 99) < 35) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_op       <= op;
        s_raw_step <= raw;
        do @(posedge aclk); while (!s_ready);

        if (op == OP_CLEAR) begin
            // History empties; the held value stays until the next sample replaces it.
            ring_fill = 0;
            ring_slot = 0;
        end else begin
            got = predict_smoothed(raw);
            smoothed_due.push_back(typed ? want : got);
        end
    endtask

    // Writes one register and mirrors it in the shadow copy; cfg_valid is left high.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            REG_SPEED_FACTOR: shadow_speed = data[SPEED_W-1:0];
            REG_MIN_STEP:     shadow_min   = data[DATA_W-1:0];
            REG_MAX_STEP:     shadow_max   = data[DATA_W-1:0];
            REG_LERP_FACTOR:  shadow_lerp  = data[LERP_W-1:0];
            default: ;
        endcase
    endtask

    // Lets every owed result drain, then waits out the deepest pipeline so that a clear
    // or a half-finished sort cannot overlap a register write.
    task automatic settle();
        s_valid <= 1'b0;
        while (smoothed_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // One phase: program all four registers, optionally poke an index past the list,
    // then send random beats. Most beats are samples inside a working range so that the
    // ring fills and the sort path is exercised; clears are rare so windows stay full.
    task automatic run_phase(input logic [CFG_DATA_W-1:0] speed, input logic [CFG_DATA_W-1:0] lo,
                             input logic [CFG_DATA_W-1:0] hi, input logic [CFG_DATA_W-1:0] lerp,
                             input bit quiet, input bit squeeze, input bit stray);
        int unsigned       roll;
        logic [DATA_W-1:0] raw;

        write_reg(REG_SPEED_FACTOR, speed);
        write_reg(REG_MIN_STEP, lo);
        write_reg(REG_MAX_STEP, hi);
        write_reg(REG_LERP_FACTOR, lerp);
        if (stray) begin
            write_reg(REG_PAST_END + CFG_IDX_W'($urandom_range(0, 11)), $urandom);
        end
        cfg_valid <= 1'b0;

        steady = quiet;
        if (squeeze) begin
            hold_req = 1'b1;
        end

        for (int n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                send_beat(OP_CLEAR, $urandom, 1'b0, '0);
            end else begin
                if (roll < 13) begin
                    raw = $urandom;
                end else if (roll < 17) begin
                    raw = roll[0] ? '1 : '0;
                end else begin
                    raw = $urandom_range(500_000, 120_000_000);
                end
                send_beat(OP_SAMPLE, raw, 1'b0, '0);
            end
        end
        steady = 1'b0;
        settle();
    endtask

    // ------------------------------------------------------------------------------------
    // Directed rows, run under the reset register values (speed 1.0, clamp 1 ms..100 ms).
    // A result is typed in only where it is plain: warm-up samples come back clamped.
    // ------------------------------------------------------------------------------------
    typedef struct packed {
        logic              op;
        logic [DATA_W-1:0] raw;
        logic              typed;
        logic [DATA_W-1:0] want;
    } plan_row_t;

    localparam int PLAN_LEN = 21;

    plan_row_t opening_plan [PLAN_LEN] = '{
        '{OP_SAMPLE, 32'd0,           1'b1, 32'd1000000},    // below min
        '{OP_SAMPLE, 32'hFFFF_FFFF,   1'b1, 32'd100000000},  // top of range, above max
        '{OP_SAMPLE, 32'd5000000,     1'b1, 32'd5000000},
        '{OP_CLEAR,  32'hFFFF_FFFF,   1'b0, 32'd0},
        '{OP_SAMPLE, 32'd1000000,     1'b1, 32'd1000000},    // exactly on min
        '{OP_SAMPLE, 32'd100000000,   1'b1, 32'd100000000},  // exactly on max
        '{OP_SAMPLE, 32'd3000000,     1'b0, 32'd0},
        '{OP_SAMPLE, 32'd12000000,    1'b0, 32'd0},
        '{OP_SAMPLE, 32'd7000000,     1'b0, 32'd0},
        '{OP_SAMPLE, 32'd90000000,    1'b0, 32'd0},
        '{OP_SAMPLE, 32'd2500000,     1'b0, 32'd0},
        '{OP_SAMPLE, 32'd16666667,    1'b0, 32'd0},
        '{OP_SAMPLE, 32'd4000000,     1'b0, 32'd0},
        '{OP_SAMPLE, 32'd8000000,     1'b0, 32'd0},
        '{OP_SAMPLE, 32'd100000000,   1'b0, 32'd0},          // first full window
        '{OP_SAMPLE, 32'd999999,      1'b0, 32'd0},
        '{OP_SAMPLE, 32'd50000000,    1'b0, 32'd0},
        '{OP_SAMPLE, 32'hFFFF_FFFF,   1'b0, 32'd0},
        '{OP_CLEAR,  32'd0,           1'b0, 32'd0},
        '{OP_SAMPLE, 32'd7777777,     1'b1, 32'd7777777},    // warm-up again after clear
        '{OP_SAMPLE, 32'h8000_0000,   1'b1, 32'd100000000}
    };

    // ------------------------------------------------------------------------------------
    // Main sequence: reset, directed rows, then phases that sweep the registers through
    // their extremes, min above max, one phase with no idling, one with a long hold-off
    // on the result side, and a few random settings.
    // ------------------------------------------------------------------------------------
    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < PLAN_LEN; r++) begin
            send_beat(opening_plan[r].op, opening_plan[r].raw,
                      opening_plan[r].typed, opening_plan[r].want);
        end
        settle();

        // Largest speed: big raw steps saturate before the clamp; widest clamp, full blend.
        run_phase(32'h00FF_FFFF, 32'd0, 32'hFFFF_FFFF, 32'd65535, 1'b0, 1'b0, 1'b0);
        // Zero speed and zero blend weight: the held value never moves after warm-up.
        run_phase(32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 1'b0, 1'b0, 1'b1);
        // Min above max: every sample ends on one of the two bounds.
        run_phase(32'd65536, 32'd50000000, 32'd20000000, 32'd32768, 1'b0, 1'b0, 1'b0);
        // A stretch with no idling on either side.
        run_phase(32'd98304, 32'd1000, 32'd10000000, 32'd13107, 1'b1, 1'b0, 1'b0);
        // Reset values again, with the receiver holding off long enough to fill the block.
        run_phase(32'(SPEED_RST), 32'(MIN_RST), 32'(MAX_RST), 32'(LERP_RST), 1'b0, 1'b1, 1'b0);

        // Random but sensible settings; min above max can come up here too.
        repeat (2) begin
            run_phase($urandom_range(16384, 400000), $urandom_range(0, 20_000_000),
                      $urandom_range(10_000_000, 150_000_000), $urandom_range(0, 65535),
                      1'b0, 1'b0, 1'b1);
        end
        // Fully random words, including the bits above each register's width.
        run_phase($urandom, $urandom, $urandom, $urandom, 1'b0, 1'b0, 1'b1);

        if (mismatch_count == 0 && smoothed_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------------------------
    // Receiver side: random idling, no idling while steady is set, and one long hold-off
    // counted here on request so the input side backs up while the sender keeps going.
    // ------------------------------------------------------------------------------------
    int unsigned hold_left = 0;

    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= steady || ($urandom_range(0, 99) >= 35);
            end
        end
    end

    // Every result beat is checked against the oldest owed step.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (smoothed_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= SHOW_LIMIT) begin
                    $display("unexpected result beat: smoothed_step %0d", m_smoothed_step);
                end
            end else begin
                if (m_smoothed_step !== smoothed_due[0]) begin
                    mismatch_count++;
                    if (mismatch_count <= SHOW_LIMIT) begin
                        $display("smoothed_step mismatch: expected %0d, got %0d",
                                 smoothed_due[0], m_smoothed_step);
                    end
                end
                void'(smoothed_due.pop_front());
            end
        end
    end

endmodule

// ===== files.f =====
hw/rtl/tmss_pkg.sv
hw/rtl/tmss_scale.sv
hw/rtl/tmss_sort_cell.sv
hw/rtl/tmss_div7.sv
hw/rtl/trimmed_mean_step_smoother_top.sv
hw/rtl/tmss_checker.sv
bench/tb_trimmed_mean_step_smoother_top.sv
